// File: sv/b64e_pkg.sv
// Package for the base64 stream encoder.
// Holds beat types, the queued command type, constants and the alphabet function.
// No dependencies.
package b64e_pkg;

  // Default depth of the command queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // Characters per full group, and the pad character
  localparam int unsigned GroupChars = 4;
  localparam logic [7:0]  PadChar    = 8'h25;  // '%'

  // Position within a three-byte group
  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2,
    PhaseUnused = 2'd3
  } phase_e;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_beat_t;

  // One input byte, classified: up to four characters to emit
  typedef struct packed {
    logic [GroupChars-1:0][7:0] chars;     // chars[0] goes out first
    logic [1:0]                 last_idx;  // index of the final char of this command
    logic                       ends_msg;  // final char closes the message
  } cmd_t;

  // Map a 6-bit code to its base64 character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    begin
      if (v < 6'd26) begin
        c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
        c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
        c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
        c = 8'h2B;  // '+'
      end else begin
        c = 8'h2F;  // '/'
      end
      return c;
    end
  endfunction

endpackage

// File: sv/b64e_front.sv
// Front end of the base64 stream encoder: accepts bytes, tracks group phase.
// Turns each byte into one queued command of up to four characters.
// Depends on b64e_pkg.
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  b64e_pkg::in_beat_t in_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output b64e_pkg::cmd_t    push_cmd_o
);
  import b64e_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       accept;
  logic [7:0] b;
  logic       last;
  cmd_t       cmd;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;
  assign b            = in_i.data_byte;
  assign last         = in_i.last_byte;

  // Classify the byte by group phase
  always_comb begin
    cmd      = '0;
    phase_d  = phase_q;
    left_d   = left_q;
    unique case (phase_q)
      PhaseSecond: begin
        cmd.chars[0] = sextet_char({left_q[1:0], b[7:4]});
        if (last) begin
          cmd.chars[1] = sextet_char({b[3:0], 2'b00});
          cmd.chars[2] = PadChar;
          cmd.last_idx = 2'd2;
          cmd.ends_msg = 1'b1;
          phase_d      = PhaseFirst;
          left_d       = '0;
        end else begin
          cmd.last_idx = 2'd0;
          phase_d      = PhaseThird;
          left_d       = b[3:0];
        end
      end
      PhaseThird: begin
        cmd.chars[0] = sextet_char({left_q, b[7:6]});
        cmd.chars[1] = sextet_char(b[5:0]);
        cmd.last_idx = 2'd1;
        cmd.ends_msg = last;
        phase_d      = PhaseFirst;
        left_d       = '0;
      end
      PhaseFirst, PhaseUnused: begin
        cmd.chars[0] = sextet_char(b[7:2]);
        if (last) begin
          cmd.chars[1] = sextet_char({b[1:0], 4'b0000});
          cmd.chars[2] = PadChar;
          cmd.chars[3] = PadChar;
          cmd.last_idx = 2'd3;
          cmd.ends_msg = 1'b1;
          phase_d      = PhaseFirst;
          left_d       = '0;
        end else begin
          cmd.last_idx = 2'd0;
          phase_d      = PhaseSecond;
          left_d       = {2'b00, b[1:0]};
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign push_cmd_o = cmd;

  // Group state advances on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

// File: sv/b64e_queue.sv
// Command queue between front and back of the base64 stream encoder.
// Small circular buffer of classified commands with a fill count.
// Depends on b64e_pkg.
module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  b64e_pkg::cmd_t push_cmd_i,
  output logic           head_valid_o,
  input  logic           pop_i,
  output b64e_pkg::cmd_t head_cmd_o,
  output logic [$clog2(Depth+1)-1:0] cnt_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign cnt_o        = cnt_q;

  // Pointer wrap and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: sv/b64e_back.sv
// Back end of the base64 stream encoder: serializes queued commands.
// One character per cycle into an output register, while a command is queued and out_ready_i allows.
// Depends on b64e_pkg.
module b64e_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  b64e_pkg::cmd_t     head_cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output b64e_pkg::out_beat_t out_o
);
  import b64e_pkg::*;

  logic      [1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_q, out_d;
  logic            load;
  logic            at_end;

  assign load   = head_valid_i && (!out_valid_q || out_ready_i);
  assign at_end = (idx_q == head_cmd_i.last_idx);
  assign pop_o  = load && at_end;

  // Next character and index
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_d.out_char  = head_cmd_i.chars[idx_q];
      out_d.last_char = head_cmd_i.ends_msg && at_end;
      out_valid_d     = 1'b1;
      idx_d           = at_end ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: sv/base64_stream_encoder_top.sv
// Base64 stream encoder, top level.
// Instantiates front, command queue and back; depends on b64e_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_i) takes one raw byte per beat,
//   with last_byte set on the final byte of a message.
//   Output channel (out_valid_o / out_ready_i / out_o) gives one ASCII character
//   per beat from the alphabet A-Z a-z 0-9 + /, with '%' as pad; last_char marks
//   the final character of each encoded message.
//   Path: an accepted byte is written into the command queue, and its characters
//   are then loaded one at a time into the output register.
//   Throughput: the back end sends one character per cycle while out_ready_i is
//   high, so a byte yields 1 to 4 characters (4 per 3 bytes, more on a short final group).
//   The input takes a byte every cycle while the command queue has room, so it
//   runs ahead of the output by up to QueueDepth bytes.
//   Stall: when out_ready_i is low the output register holds; the queue fills,
//   then in_ready_o drops until the back end drains a command.
//   Reset: rst_ni low clears group phase, queue and output valid; the block
//   starts at a group boundary.
module base64_stream_encoder_top #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64e_pkg::in_beat_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64e_pkg::out_beat_t out_o
);
  import b64e_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic            push_valid;
  logic            push_ready;
  cmd_t            push_cmd;
  logic            head_valid;
  cmd_t            head_cmd;
  logic            pop;
  logic [CntW-1:0] q_cnt;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_cmd_o   (head_cmd),
    .cnt_o        (q_cnt)
  );

  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

`ifndef SYNTHESIS
  // Queue fill never exceeds its depth
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= CntW'(QueueDepth))
    else $error("command queue overfilled");

  // Back end never pops an empty queue
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty command queue");

  // Fill count goes up by one on an accepted push with no pop
  a_cnt_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !pop) |=> (q_cnt == $past(q_cnt) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

// File: dv/base64_stream_encoder_top_tb.sv
// Testbench for base64_stream_encoder_top: byte beats in, checked character beats out.
// Predicts the character stream from each accepted byte and compares in order.
// Depends on b64e_pkg and the encoder RTL.
`timescale 1ns / 1ps

module base64_stream_encoder_top_tb;
  import b64e_pkg::*;

  // Base64 alphabet, first character in the top byte
  localparam logic [511:0] B64_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int unsigned IDLE_PCT = 33;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CALM_FIRST = 120;  // no idling while this many ...
  localparam int unsigned CALM_LAST = 180;   // ... up to this many bytes are sent

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  in_beat_t  byte_q[$];   // bytes waiting to be sent
  out_beat_t char_q[$];   // characters predicted, not yet seen

  // Encoder state mirrored for prediction
  phase_e     grp_phase = PhaseFirst;
  logic [3:0] carry_bits = '0;

  int unsigned n_sent = 0;
  int unsigned n_msgs = 0;
  int unsigned n_chars = 0;
  int unsigned n_errors = 0;

  base64_stream_encoder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_beat)
  );

  // Clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] code);
    return B64_ALPHA[(63 - int'(code)) * 8 +: 8];
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic l);
    out_beat_t ob;
    ob.out_char  = c;
    ob.last_char = l;
    char_q.push_back(ob);
  endfunction

  // Predict the characters caused by one accepted byte
  function automatic void encode_byte(input in_beat_t ib);
    logic [7:0] d;
    d = ib.data_byte;
    case (grp_phase)
      PhaseSecond: begin
        // only the low two carried bits belong to this character
        push_char(b64_char({carry_bits[1:0], d[7:4]}), 1'b0);
        if (ib.last_byte) begin
          push_char(b64_char({d[3:0], 2'b00}), 1'b0);
          push_char(PadChar, 1'b1);
          grp_phase  = PhaseFirst;
          carry_bits = '0;
        end else begin
          grp_phase  = PhaseThird;
          carry_bits = d[3:0];
        end
      end
      PhaseThird: begin
        push_char(b64_char({carry_bits, d[7:6]}), 1'b0);
        push_char(b64_char(d[5:0]), ib.last_byte);
        grp_phase  = PhaseFirst;
        carry_bits = '0;
      end
      default: begin
        push_char(b64_char(d[7:2]), 1'b0);
        if (ib.last_byte) begin
          push_char(b64_char({d[1:0], 4'b0000}), 1'b0);
          push_char(PadChar, 1'b0);
          push_char(PadChar, 1'b1);
          grp_phase  = PhaseFirst;
          carry_bits = '0;
        end else begin
          grp_phase  = PhaseSecond;
          carry_bits = {2'b00, d[1:0]};
        end
      end
    endcase
    if (ib.last_byte) n_msgs++;
  endfunction

  // Driver: present queued bytes, idle at random outside the calm stretch
  always @(posedge clk_i) begin
    logic took;
    logic calm;
    if (rst_ni) begin
      took = in_valid && in_ready;
      calm = (n_sent >= CALM_FIRST) && (n_sent < CALM_LAST);
      if (took) begin
        encode_byte(in_beat);
        n_sent <= n_sent + 1;
      end
      if (!in_valid || took) begin
        if (byte_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_beat  <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each character beat against the oldest prediction
  always @(posedge clk_i) begin
    out_beat_t want;
    logic calm;
    if (rst_ni) begin
      calm = (n_sent >= CALM_FIRST) && (n_sent < CALM_LAST);
      if (out_valid && out_ready) begin
        n_chars++;
        if (char_q.size() == 0) begin
          $error("unexpected character beat: out_char=%h last_char=%b",
                 out_beat.out_char, out_beat.last_char);
          n_errors++;
        end else begin
          want = char_q.pop_front();
          if (out_beat.out_char !== want.out_char) begin
            $error("out_char mismatch: expected %h, actual %h",
                   want.out_char, out_beat.out_char);
            n_errors++;
          end
          if (out_beat.last_char !== want.last_char) begin
            $error("last_char mismatch: expected %b, actual %b",
                   want.last_char, out_beat.last_char);
            n_errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic l);
    in_beat_t ib;
    ib.data_byte = d;
    ib.last_byte = l;
    byte_q.push_back(ib);
  endtask

  // Random message, mostly short, sometimes long
  task automatic push_message();
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(1, 6);
    else if (pick < 95) len = $urandom_range(7, 16);
    else len = $urandom_range(17, 40);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(8'($urandom()), i == len - 1);
    end
  endtask

  // Hold off until every queued byte is sent and every character has come
  task automatic wait_drained();
    while (byte_q.size() > 0 || in_valid || char_q.size() > 0) @(posedge clk_i);
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned rand_bytes;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-byte, two-byte and three-byte messages at the extremes
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
    push_byte(8'hFB, 1'b0); push_byte(8'hEF, 1'b0); push_byte(8'hBE, 1'b1);  // all '+'
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);  // all '/'
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
    // two full groups, then a full group and a close on the first byte of the next
    push_byte(8'h4D, 1'b0); push_byte(8'h61, 1'b0); push_byte(8'h6E, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h7F, 1'b1);
    push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b0); push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    wait_drained();

    // Random messages; a full drain partway through if the byte count lands in 115 to 129
    rand_bytes = 0;
    while (rand_bytes < 205) begin
      push_message();
      rand_bytes = byte_q.size() + n_sent - 25;
      if (rand_bytes >= 115 && rand_bytes < 130) begin
        wait_drained();
        rand_bytes = n_sent - 25;
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Summary: %0d bytes in %0d messages encoded, %0d characters checked",
             n_sent, n_msgs, n_chars);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Timeout: %0d characters still expected", char_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
